/* hdl/multilevel_queue_tick_scheduler_assert.svh */
// Assertion macros for the multilevel queue tick scheduler.
// Used by the checker module; no other dependencies.
`ifndef MULTILEVEL_QUEUE_TICK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MQTS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MQTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mqts_pkg.sv */
// Shared types, constants and helper functions of the tick scheduler.
// No dependencies; every module imports this package.
package mqts_pkg;

    localparam int MAX_PROCS_DEFAULT = 32;
    localparam int NUM_LEVELS        = 5;
    localparam int SLOT_W            = 5;
    localparam int MAX_SLOTS         = 2 ** SLOT_W;
    localparam int PID_W             = 16;
    localparam int LEVEL_W           = 3;
    localparam int PRIO_W            = 8;
    localparam int BURST_W           = 16;
    localparam int ARRIVAL_W         = 32;
    localparam int KEY_W             = 32;
    localparam int SLICE_W           = 8;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;

    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic REG_TIME_SLICE = 1'b0;
    localparam logic [SLICE_W-1:0] TIME_SLICE_RESET = SLICE_W'(1);

    localparam logic [LEVEL_W-1:0] LEVEL_PRIO      = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] LEVEL_FCFS_LAST = LEVEL_W'(2);
    localparam logic [LEVEL_W-1:0] LEVEL_LAST      = LEVEL_W'(NUM_LEVELS - 1);

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [PID_W-1:0]   pid;
        logic [LEVEL_W-1:0] level;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } in_item_t;

    typedef struct packed {
        logic               idle;
        logic [SLOT_W-1:0]  run_slot;
        logic [PID_W-1:0]   run_pid;
        logic [LEVEL_W-1:0] run_level;
        logic               finished;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [PRIO_W-1:0]    prio;
        logic [PID_W-1:0]     pid;
        logic [ARRIVAL_W-1:0] arrival;
        logic [BURST_W-1:0]   remaining;
    } entry_t;

    typedef struct packed {
        logic arrive_wr;
        logic tick_start;
        logic scan_rd;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic any_valid;
        logic scan_last;
        logic out_free;
    } dp_sts_t;

    typedef enum logic [1:0] {
        ST_IN,
        ST_SCAN,
        ST_LAST,
        ST_FIN
    } state_t;

    function automatic logic [KEY_W-1:0] key_of(entry_t e, logic [LEVEL_W-1:0] lvl);
        logic [KEY_W-1:0] k;
        if (lvl == LEVEL_PRIO) begin
            k = KEY_W'(e.prio);
        end else if (lvl <= LEVEL_FCFS_LAST) begin
            k = KEY_W'(e.arrival);
        end else begin
            k = KEY_W'(e.remaining);
        end
        return k;
    endfunction

    function automatic logic [LEVEL_W-1:0] next_level(logic [LEVEL_W-1:0] lvl);
        logic [LEVEL_W-1:0] n;
        if (lvl >= LEVEL_LAST) begin
            n = '0;
        end else begin
            n = lvl + LEVEL_W'(1);
        end
        return n;
    endfunction

endpackage

/* hdl/mqts_cfg.sv */
// APB-style register port holding time_slice.
// Depends on mqts_pkg.
module mqts_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mqts_pkg::PADDR_W-1:0] paddr,
    input  logic [mqts_pkg::PDATA_W-1:0] pwdata,
    output logic [mqts_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [mqts_pkg::SLICE_W-1:0] time_slice
);
    import mqts_pkg::*;

    logic [SLICE_W-1:0] time_slice_reg;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_TIME_SLICE) && (paddr[1:0] == 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_slice_reg <= TIME_SLICE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_TIME_SLICE) begin
            time_slice_reg <= pwdata[SLICE_W-1:0];
        end
    end

    always_comb begin
        if (reg_sel) begin
            prdata = PDATA_W'(time_slice_reg);
        end else begin
            prdata = '0;
        end
    end

    assign time_slice = time_slice_reg;

endmodule

/* hdl/mqts_ctrl.sv */
// Controller state machine: accept, table scan, result hand-off.
// Depends on mqts_pkg; drives mqts_dp through command and status structs.
module mqts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_kind,
    output logic                 s_ready,
    input  mqts_pkg::dp_sts_t    sts,
    output mqts_pkg::ctrl_cmd_t  cmd
);
    import mqts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IN: begin
                if (s_valid && s_kind == KIND_TICK) begin
                    state_next = sts.any_valid ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    state_next = ST_IN;
                end
            end
            default: begin
                state_next = ST_IN;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IN: begin
                s_ready        = 1'b1;
                cmd.arrive_wr  = s_valid && (s_kind == KIND_ARRIVE);
                cmd.tick_start = s_valid && (s_kind == KIND_TICK);
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
            end
            ST_LAST: begin
                cmd = '0;
            end
            ST_FIN: begin
                cmd.finish = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/mqts_dp.sv */
// Datapath: process table, level counts, best-entry comparator, output register.
// Depends on mqts_pkg; controlled by mqts_ctrl.
module mqts_dp #(
    parameter int MAX_PROCS = mqts_pkg::MAX_PROCS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mqts_pkg::in_item_t           s_data,
    input  mqts_pkg::ctrl_cmd_t          cmd,
    input  logic [mqts_pkg::SLICE_W-1:0] time_slice,
    input  logic                         m_ready,
    output mqts_pkg::dp_sts_t            sts,
    output logic                         m_valid,
    output mqts_pkg::out_item_t          m_data
);
    import mqts_pkg::*;

    localparam int DEPTH = (MAX_PROCS < MAX_SLOTS) ? MAX_PROCS : MAX_SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    entry_t               mem [DEPTH];
    entry_t               rdata_reg;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic [DEPTH-1:0]     valid_reg;
    logic [CNT_W-1:0]     count_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] occ;

    logic [LEVEL_W-1:0]   cur_level_reg;
    logic [SLICE_W-1:0]   slice_reg;
    logic [ARRIVAL_W-1:0] now_reg;

    logic [IDX_W-1:0]     scan_addr_reg;
    logic                 cmp_en_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [LEVEL_W-1:0]   serve_lvl_reg;
    logic [SLICE_W-1:0]   slice_base_reg;
    logic                 idle_reg;
    logic                 have_best_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    entry_t               best_reg;

    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic [IDX_W-1:0]     arr_idx;
    logic                 arr_wr;
    logic [LEVEL_W:0]     lv_sum;
    logic                 found;
    logic [LEVEL_W-1:0]   pick_level;
    logic                 cand;
    logic                 better;
    logic [KEY_W-1:0]     k_new;
    logic [KEY_W-1:0]     k_best;
    logic [BURST_W-1:0]   rem_dec;
    logic                 fin;
    logic [SLICE_W-1:0]   slice_inc;
    logic                 fin_wr;

    // Arrival check and table write.
    assign arr_idx = s_data.slot[IDX_W-1:0];
    assign arr_wr  = cmd.arrive_wr
                  && (32'(s_data.slot) < 32'(MAX_PROCS))
                  && !valid_reg[arr_idx]
                  && (s_data.level < LEVEL_W'(NUM_LEVELS))
                  && (s_data.burst != '0);

    assign rem_dec   = best_reg.remaining - BURST_W'(1);
    assign fin       = (rem_dec == '0);
    assign slice_inc = slice_base_reg + SLICE_W'(1);
    assign fin_wr    = cmd.finish && !idle_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = best_idx_reg;
        wr_data = best_reg;
        wr_data.remaining = rem_dec;
        if (arr_wr) begin
            wr_en             = 1'b1;
            wr_addr           = arr_idx;
            wr_data.level     = s_data.level;
            wr_data.prio      = s_data.prio;
            wr_data.pid       = s_data.pid;
            wr_data.arrival   = now_reg;
            wr_data.remaining = s_data.burst;
        end else if (fin_wr) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[scan_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (arr_wr) begin
            valid_reg[arr_idx] <= 1'b1;
        end else if (fin_wr && fin) begin
            valid_reg[best_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                count_reg[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (arr_wr && s_data.level == LEVEL_W'(l)) begin
                    count_reg[l] <= count_reg[l] + CNT_W'(1);
                end else if (fin_wr && fin && serve_lvl_reg == LEVEL_W'(l)) begin
                    count_reg[l] <= count_reg[l] - CNT_W'(1);
                end
            end
        end
    end

    // Pick the first occupied level from the current one onward.
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            occ[l] = (count_reg[l] != '0);
        end
        found      = 1'b0;
        pick_level = cur_level_reg;
        lv_sum     = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            lv_sum = (LEVEL_W + 1)'(cur_level_reg) + (LEVEL_W + 1)'(k);
            if (lv_sum >= (LEVEL_W + 1)'(NUM_LEVELS)) begin
                lv_sum = lv_sum - (LEVEL_W + 1)'(NUM_LEVELS);
            end
            if (!found && occ[lv_sum[LEVEL_W-1:0]]) begin
                found      = 1'b1;
                pick_level = lv_sum[LEVEL_W-1:0];
            end
        end
    end

    // Scan address and compare stage.
    assign k_new  = key_of(rdata_reg, serve_lvl_reg);
    assign k_best = key_of(best_reg, serve_lvl_reg);
    assign cand   = cmp_en_reg && valid_reg[cmp_idx_reg] && (rdata_reg.level == serve_lvl_reg);
    assign better = !have_best_reg || (k_new < k_best)
                 || ((k_new == k_best) && (rdata_reg.pid < best_reg.pid));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_addr_reg;
        if (cmd.tick_start) begin
            scan_addr_reg  <= '0;
            serve_lvl_reg  <= pick_level;
            slice_base_reg <= (pick_level == cur_level_reg) ? slice_reg : '0;
            idle_reg       <= !sts.any_valid;
            have_best_reg  <= 1'b0;
        end else begin
            if (cmd.scan_rd) begin
                scan_addr_reg <= scan_addr_reg + IDX_W'(1);
            end
            if (cand && better) begin
                best_reg      <= rdata_reg;
                best_idx_reg  <= cmp_idx_reg;
                have_best_reg <= 1'b1;
            end
        end
    end

    // Rotation, tick counter and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_level_reg <= '0;
            slice_reg     <= '0;
            now_reg       <= '0;
        end else if (cmd.finish) begin
            now_reg <= now_reg + ARRIVAL_W'(1);
            if (idle_reg) begin
                cur_level_reg <= '0;
                slice_reg     <= '0;
            end else if (slice_inc >= time_slice) begin
                cur_level_reg <= next_level(serve_lvl_reg);
                slice_reg     <= '0;
            end else begin
                cur_level_reg <= serve_lvl_reg;
                slice_reg     <= slice_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (idle_reg) begin
                m_data_reg.idle      <= 1'b1;
                m_data_reg.run_slot  <= '0;
                m_data_reg.run_pid   <= '0;
                m_data_reg.run_level <= '0;
                m_data_reg.finished  <= 1'b0;
            end else begin
                m_data_reg.idle      <= 1'b0;
                m_data_reg.run_slot  <= SLOT_W'(best_idx_reg);
                m_data_reg.run_pid   <= best_reg.pid;
                m_data_reg.run_level <= serve_lvl_reg;
                m_data_reg.finished  <= fin;
            end
        end
    end

    assign sts.any_valid = |valid_reg;
    assign sts.scan_last = (scan_addr_reg == LAST_IDX);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/multilevel_queue_tick_scheduler.sv */
// Top level of the multilevel queue tick scheduler.
// Depends on mqts_pkg, mqts_cfg, mqts_ctrl and mqts_dp.
//
// Input channel s_*: each transaction is either a process arrival (kind 0),
// which writes one table slot and gives no result, or a time tick (kind 1),
// which gives exactly one result transaction on m_*.
// An arrival leaves s_ready high, so arrivals follow back to back.
// A tick scans the min(MAX_PROCS, 32) table slots one slot per cycle through
// a single comparator, then completes the last compare and loads the result
// register once it is free; s_ready stays low until the tick is done.
// A tick with an empty table skips the scan and goes straight to the result step.
// The result sits in an output register; the next transaction is taken
// while it waits. When the receiver stalls and a second tick result is ready,
// the block holds in its final step until m_ready frees the register.
// Reset (aresetn low, synchronous) empties the table, returns the rotation
// to level 0, clears the tick counter and sets time_slice to 1.
// time_slice lies at APB byte address 0; write it only while idle.
module multilevel_queue_tick_scheduler #(
    parameter int MAX_PROCS = mqts_pkg::MAX_PROCS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  mqts_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output mqts_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mqts_pkg::PADDR_W-1:0] paddr,
    input  logic [mqts_pkg::PDATA_W-1:0] pwdata,
    output logic [mqts_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import mqts_pkg::*;

    logic [SLICE_W-1:0] time_slice;
    ctrl_cmd_t          cmd;
    dp_sts_t            sts;

    mqts_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .time_slice (time_slice)
    );

    mqts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mqts_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .cmd        (cmd),
        .time_slice (time_slice),
        .m_ready    (m_ready),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

endmodule

/* hdl/mqts_checker.sv */
// Port-level checker for the tick scheduler, bound to the top level.
// Depends on mqts_pkg and multilevel_queue_tick_scheduler_assert.svh.
`include "multilevel_queue_tick_scheduler_assert.svh"

module mqts_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mqts_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mqts_pkg::out_item_t m_data
);
    import mqts_pkg::*;

    `MQTS_ASSERT_SAME(a_idle_zero, aclk, aresetn, m_valid && m_data.idle, m_data.run_slot == '0 && m_data.run_pid == '0 && m_data.run_level == '0 && !m_data.finished, "idle result carries nonzero fields")
    `MQTS_ASSERT_SAME(a_level_range, aclk, aresetn, m_valid && !m_data.idle, m_data.run_level <= LEVEL_LAST, "served level out of range")
    `MQTS_ASSERT_NEXT(a_tick_busy, aclk, aresetn, s_valid && s_ready && s_data.kind == KIND_TICK, !s_ready, "transaction taken while a tick is in work")
    `MQTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result transaction changed")

endmodule

bind multilevel_queue_tick_scheduler mqts_checker u_checker (.*);
